// File: rtl/core/cplc_pkg.sv
package cplc_pkg;

   localparam int unsigned IDX_W = 4;
   localparam int unsigned PTR_W = 5;

   typedef enum logic [1:0] {
      OP_STEP  = 2'd0,
      OP_LOAD  = 2'd1,
      OP_QUEUE = 2'd2,
      OP_FREE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_NONE  = 2'd0,
      STATUS_NEW   = 2'd1,
      STATUS_SAME  = 2'd2,
      STATUS_ERROR = 2'd3
   } status_type;

   localparam logic [2:0] CSR_ERROR_DELAY = 3'd0;
   localparam logic [7:0] ERROR_DELAY_RESET = 8'd128;

   // one write into a byte store
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [7:0]       data;
   } store_write_type;

   // result fields produced by the link machine
   typedef struct packed {
      logic       rx_taken;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       dir_level;
      logic [1:0] cmd_status;
      logic       send_busy;
      logic       send_accepted;
   } link_result_type;

   // body length including the opcode, by low opcode nibble
   function automatic logic [3:0] body_length(input logic [3:0] nibble);
      logic [3:0] len;
      case (nibble)
         4'd1:    len = 4'd2;
         4'd4:    len = 4'd12;
         4'd5:    len = 4'd2;
         4'd8:    len = 4'd4;
         4'd13:   len = 4'd2;
         default: len = 4'd1;
      endcase
      return len;
   endfunction

endpackage

// File: rtl/core/cplc_rx_buf.sv
module cplc_rx_buf #(
   parameter int unsigned RX_DEPTH = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cplc_pkg::store_write_type       wr,
   input  logic [cplc_pkg::IDX_W-1:0]      rd_idx,
   output logic [7:0]                      rd_data,
   output logic [7:0]                      opcode_byte
);

   localparam int unsigned AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam logic [cplc_pkg::IDX_W:0] DEPTH_W = (cplc_pkg::IDX_W + 1)'(RX_DEPTH);

   logic [7:0] mem_ff [RX_DEPTH];
   logic       wr_ok;
   logic       rd_ok;

   assign wr_ok = wr.en && ({1'b0, wr.addr} < DEPTH_W);
   assign rd_ok = {1'b0, rd_idx} < DEPTH_W;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RX_DEPTH; i++) begin
            mem_ff[i] <= 8'd0;
         end
      end else if (wr_ok) begin
         mem_ff[wr.addr[AW-1:0]] <= wr.data;
      end
   end

   // read shows the store after this item's write
   always_comb begin
      if (!rd_ok) begin
         rd_data = 8'd0;
      end else if (wr_ok && (wr.addr == rd_idx)) begin
         rd_data = wr.data;
      end else begin
         rd_data = mem_ff[rd_idx[AW-1:0]];
      end
   end

   assign opcode_byte = mem_ff[0];

endmodule

// File: rtl/core/cplc_tx_buf.sv
module cplc_tx_buf #(
   parameter int unsigned TX_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cplc_pkg::store_write_type       wr,
   input  logic [cplc_pkg::PTR_W-1:0]      rd_ptr,
   output logic [7:0]                      rd_data
);

   localparam int unsigned AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam logic [cplc_pkg::PTR_W-1:0] DEPTH_W = cplc_pkg::PTR_W'(TX_DEPTH);

   logic [7:0] mem_ff [TX_DEPTH];
   logic       wr_ok;

   assign wr_ok = wr.en && ({1'b0, wr.addr} < DEPTH_W);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TX_DEPTH; i++) begin
            mem_ff[i] <= 8'd0;
         end
      end else if (wr_ok) begin
         mem_ff[wr.addr[AW-1:0]] <= wr.data;
      end
   end

   // pointer past the store sends zero
   assign rd_data = (rd_ptr < DEPTH_W) ? mem_ff[rd_ptr[AW-1:0]] : 8'd0;

endmodule

// File: rtl/core/cplc_link_fsm.sv
module cplc_link_fsm #(
   parameter int unsigned TX_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [1:0]                      op,
   input  logic                            data_level,
   input  logic [7:0]                      rx_byte,
   input  logic [7:0]                      load_byte,
   input  logic [cplc_pkg::IDX_W-1:0]      buf_index,
   input  logic [4:0]                      send_length,
   input  logic                            with_checksum,
   input  logic [7:0]                      error_delay,
   input  logic [7:0]                      opcode_byte,
   input  logic [7:0]                      tx_data,
   output logic [cplc_pkg::PTR_W-1:0]      tx_ptr,
   output cplc_pkg::store_write_type       rx_wr,
   output cplc_pkg::store_write_type       tx_wr,
   output cplc_pkg::link_result_type       result
);

   typedef enum logic [6:0] {
      LS_IDLE    = 7'b0000001,
      LS_RX_OP   = 7'b0000010,
      LS_RX_PARM = 7'b0000100,
      LS_RX_CHK  = 7'b0001000,
      LS_TX_DATA = 7'b0010000,
      LS_TX_CHK  = 7'b0100000,
      LS_ERR     = 7'b1000000
   } link_state_type;

   localparam logic [4:0] TX_DEPTH_W = 5'(TX_DEPTH);

   link_state_type state_ff, state_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [3:0] expected_length_ff, expected_length_in;
   logic [3:0] rx_count_ff, rx_count_in;
   logic [4:0] tx_pointer_ff, tx_pointer_in;
   logic [4:0] tx_remaining_ff, tx_remaining_in;
   logic [7:0] error_countdown_ff, error_countdown_in;
   logic [7:0] last_opcode_ff, last_opcode_in;
   logic [1:0] result_code_ff, result_code_in;
   logic       report_pending_ff, report_pending_in;
   logic       send_pending_ff, send_pending_in;
   logic       sum_wanted_ff, sum_wanted_in;
   logic       dir_ff, dir_in;

   logic       taken;
   logic       txv;
   logic [7:0] txb;
   logic       accepted;
   logic [7:0] sum_add;
   logic [3:0] count_next;
   logic [4:0] remaining_dec;

   assign tx_ptr        = tx_pointer_ff;
   assign sum_add       = running_sum_ff + rx_byte;
   assign count_next    = rx_count_ff + 4'd1;
   assign remaining_dec = (tx_remaining_ff != 5'd0) ? tx_remaining_ff - 5'd1 : tx_remaining_ff;

   always_comb begin
      state_in           = state_ff;
      running_sum_in     = running_sum_ff;
      expected_length_in = expected_length_ff;
      rx_count_in        = rx_count_ff;
      tx_pointer_in      = tx_pointer_ff;
      tx_remaining_in    = tx_remaining_ff;
      error_countdown_in = error_countdown_ff;
      last_opcode_in     = last_opcode_ff;
      result_code_in     = result_code_ff;
      report_pending_in  = report_pending_ff;
      send_pending_in    = send_pending_ff;
      sum_wanted_in      = sum_wanted_ff;
      dir_in             = dir_ff;
      taken              = 1'b0;
      txv                = 1'b0;
      txb                = 8'd0;
      accepted           = 1'b0;
      rx_wr.en           = 1'b0;
      rx_wr.addr         = rx_count_ff;
      rx_wr.data         = rx_byte;
      tx_wr.en           = 1'b0;
      tx_wr.addr         = buf_index;
      tx_wr.data         = load_byte;

      case (cplc_pkg::op_type'(op))
         cplc_pkg::OP_LOAD: begin
            tx_wr.en = accept && !send_pending_ff;
         end
         cplc_pkg::OP_QUEUE: begin
            if (!send_pending_ff && (send_length != 5'd0) && (send_length <= TX_DEPTH_W)) begin
               tx_remaining_in = send_length;
               sum_wanted_in   = with_checksum;
               send_pending_in = 1'b1;
               accepted        = 1'b1;
            end
         end
         cplc_pkg::OP_FREE: begin
            report_pending_in = 1'b0;
         end
         default: begin
            unique case (state_ff)
               LS_IDLE: begin
                  // a pending send wins over a low line
                  if (send_pending_ff) begin
                     tx_pointer_in  = 5'd0;
                     running_sum_in = 8'd0;
                     state_in       = LS_TX_DATA;
                  end else if (!data_level) begin
                     rx_count_in    = 4'd0;
                     running_sum_in = 8'd0;
                     state_in       = LS_RX_OP;
                  end
               end
               LS_RX_OP: begin
                  taken  = 1'b1;
                  dir_in = 1'b0;
                  if (rx_byte == 8'd0) begin
                     error_countdown_in = error_delay;
                     state_in           = LS_ERR;
                  end else begin
                     rx_wr.en           = accept;
                     rx_wr.addr         = '0;
                     running_sum_in     = rx_byte;
                     rx_count_in        = 4'd1;
                     expected_length_in = cplc_pkg::body_length(rx_byte[3:0]);
                     state_in = (expected_length_in == 4'd1) ? LS_RX_CHK : LS_RX_PARM;
                  end
               end
               LS_RX_PARM: begin
                  if (!data_level) begin
                     taken          = 1'b1;
                     dir_in         = 1'b0;
                     rx_wr.en       = accept;
                     rx_count_in    = count_next;
                     running_sum_in = sum_add;
                     if (count_next >= expected_length_ff) begin
                        state_in = LS_RX_CHK;
                     end
                  end
               end
               LS_RX_CHK: begin
                  if (!data_level) begin
                     taken  = 1'b1;
                     dir_in = 1'b0;
                     if (~rx_byte == running_sum_ff) begin
                        if (opcode_byte == last_opcode_ff) begin
                           result_code_in = cplc_pkg::STATUS_SAME;
                        end else begin
                           result_code_in = cplc_pkg::STATUS_NEW;
                           last_opcode_in = opcode_byte;
                        end
                     end else begin
                        result_code_in = cplc_pkg::STATUS_ERROR;
                     end
                     report_pending_in = 1'b1;
                     running_sum_in    = 8'd0;
                     state_in          = LS_IDLE;
                  end
               end
               LS_TX_DATA: begin
                  if (data_level) begin
                     txv             = 1'b1;
                     txb             = tx_data;
                     running_sum_in  = running_sum_ff + tx_data;
                     tx_pointer_in   = tx_pointer_ff + 5'd1;
                     dir_in          = 1'b1;
                     tx_remaining_in = remaining_dec;
                     if (remaining_dec == 5'd0) begin
                        send_pending_in = 1'b0;
                        state_in        = sum_wanted_ff ? LS_TX_CHK : LS_IDLE;
                     end
                  end
               end
               LS_TX_CHK: begin
                  if (data_level) begin
                     txv            = 1'b1;
                     txb            = ~running_sum_ff;
                     running_sum_in = 8'd0;
                     dir_in         = 1'b1;
                     state_in       = LS_IDLE;
                  end
               end
               LS_ERR: begin
                  if (error_countdown_ff != 8'd0) begin
                     error_countdown_in = error_countdown_ff - 8'd1;
                  end else begin
                     result_code_in    = cplc_pkg::STATUS_ERROR;
                     report_pending_in = 1'b1;
                     state_in          = LS_IDLE;
                  end
               end
               default: begin
                  state_in = LS_IDLE;
               end
            endcase
         end
      endcase
   end

   always_comb begin
      result.rx_taken      = taken;
      result.tx_valid      = txv;
      result.tx_byte       = txb;
      result.dir_level     = dir_in;
      result.cmd_status    = report_pending_in ? result_code_in : cplc_pkg::STATUS_NONE;
      result.send_busy     = (state_in == LS_TX_DATA) || (state_in == LS_TX_CHK);
      result.send_accepted = accepted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= LS_IDLE;
         running_sum_ff     <= 8'd0;
         expected_length_ff <= 4'd0;
         rx_count_ff        <= 4'd0;
         tx_pointer_ff      <= 5'd0;
         tx_remaining_ff    <= 5'd0;
         error_countdown_ff <= 8'd0;
         last_opcode_ff     <= 8'd0;
         result_code_ff     <= 2'd0;
         report_pending_ff  <= 1'b0;
         send_pending_ff    <= 1'b0;
         sum_wanted_ff      <= 1'b0;
         dir_ff             <= 1'b1;
      end else if (accept) begin
         state_ff           <= state_in;
         running_sum_ff     <= running_sum_in;
         expected_length_ff <= expected_length_in;
         rx_count_ff        <= rx_count_in;
         tx_pointer_ff      <= tx_pointer_in;
         tx_remaining_ff    <= tx_remaining_in;
         error_countdown_ff <= error_countdown_in;
         last_opcode_ff     <= last_opcode_in;
         result_code_ff     <= result_code_in;
         report_pending_ff  <= report_pending_in;
         send_pending_ff    <= send_pending_in;
         sum_wanted_ff      <= sum_wanted_in;
         dir_ff             <= dir_in;
      end
   end

`ifndef SYNTHESIS
   // data bytes go out only while the send is still owed
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == LS_TX_DATA) |-> send_pending_ff)
      else $error("send data state without pending send");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == LS_RX_PARM) |-> (rx_count_ff < expected_length_ff))
      else $error("parameter count reached body length without leaving");

   assert property (@(posedge clock) disable iff (reset)
      (accept && result.tx_valid) |=> dir_ff)
      else $error("direction not set after a sent byte");
`endif

endmodule

// File: rtl/core/command_packet_link_controller_core.sv
// channel  | valid      | stall      | payload
// ---------+------------+------------+-----------------------------------------------
// request  | req_valid  | req_stall  | req_op, req_data_level, req_rx_byte, ...
// response | rsp_valid  | rsp_stall  | rsp_rx_taken, rsp_tx_valid, ... rsp_read_byte
// config   | psel       | -          | penable, pwrite, paddr, pwdata, prdata, pready
//
// one item per cycle unless req_stall is high: the link step is combinational and
// lands in the response register, so the next item is taken while the last result
// waits. req_stall is raised only while a result is held and rsp_stall is high.
// reset is synchronous: idle link, empty stores, error_delay back to 128.
module command_packet_link_controller_core #(
   parameter int unsigned RX_DEPTH = 12,
   parameter int unsigned TX_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic        req_data_level,
   input  logic [7:0]  req_rx_byte,
   input  logic [7:0]  req_load_byte,
   input  logic [3:0]  req_buf_index,
   input  logic [4:0]  req_send_length,
   input  logic        req_with_checksum,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_rx_taken,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_dir_level,
   output logic [1:0]  rsp_cmd_status,
   output logic        rsp_send_busy,
   output logic        rsp_send_accepted,
   output logic [7:0]  rsp_read_byte,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic                              accept;
   logic [7:0]                        error_delay_ff;
   logic                              rsp_valid_ff;
   cplc_pkg::link_result_type         result;
   cplc_pkg::link_result_type         result_ff;
   logic [7:0]                        read_byte;
   logic [7:0]                        read_byte_ff;
   cplc_pkg::store_write_type         rx_wr;
   cplc_pkg::store_write_type         tx_wr;
   logic [cplc_pkg::PTR_W-1:0]        tx_ptr;
   logic [7:0]                        tx_data;
   logic [7:0]                        opcode_byte;
   logic                              csr_hit;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // register file: error_delay only
   assign pready  = 1'b1;
   assign csr_hit = ({paddr[2], 2'b00} == cplc_pkg::CSR_ERROR_DELAY);
   assign prdata  = csr_hit ? {24'd0, error_delay_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         error_delay_ff <= cplc_pkg::ERROR_DELAY_RESET;
      end else if (psel && penable && pwrite && csr_hit) begin
         error_delay_ff <= pwdata[7:0];
      end
   end

   cplc_link_fsm #(
      .TX_DEPTH(TX_DEPTH)
   ) u_fsm (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .op            (req_op),
      .data_level    (req_data_level),
      .rx_byte       (req_rx_byte),
      .load_byte     (req_load_byte),
      .buf_index     (req_buf_index),
      .send_length   (req_send_length),
      .with_checksum (req_with_checksum),
      .error_delay   (error_delay_ff),
      .opcode_byte   (opcode_byte),
      .tx_data       (tx_data),
      .tx_ptr        (tx_ptr),
      .rx_wr         (rx_wr),
      .tx_wr         (tx_wr),
      .result        (result)
   );

   cplc_rx_buf #(
      .RX_DEPTH(RX_DEPTH)
   ) u_rx_buf (
      .clock       (clock),
      .reset       (reset),
      .wr          (rx_wr),
      .rd_idx      (req_buf_index),
      .rd_data     (read_byte),
      .opcode_byte (opcode_byte)
   );

   cplc_tx_buf #(
      .TX_DEPTH(TX_DEPTH)
   ) u_tx_buf (
      .clock   (clock),
      .reset   (reset),
      .wr      (tx_wr),
      .rd_ptr  (tx_ptr),
      .rd_data (tx_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff    <= result;
         read_byte_ff <= read_byte;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rx_taken      = result_ff.rx_taken;
   assign rsp_tx_valid      = result_ff.tx_valid;
   assign rsp_tx_byte       = result_ff.tx_byte;
   assign rsp_dir_level     = result_ff.dir_level;
   assign rsp_cmd_status    = result_ff.cmd_status;
   assign rsp_send_busy     = result_ff.send_busy;
   assign rsp_send_accepted = result_ff.send_accepted;
   assign rsp_read_byte     = read_byte_ff;

`ifndef SYNTHESIS
   // every taken item leaves a result behind it
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("request stalled with an empty response register");

   assert property (@(posedge clock) disable iff (reset)
      (accept && result.tx_valid) |-> (result.tx_valid != result.rx_taken))
      else $error("one item both sent and received a byte");
`endif

endmodule
